@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the envelope generator RTL. ASSERT_CLK expects
// signals named clk and rst, ASSERT_ALWAYS one named clk, in the scope of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes, state types and control structs of the linear ADSR
// envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int LEVEL_W            = 17;
  localparam int PHASE_W            = 3;
  localparam int LEN_W              = 24;
  localparam int CFG_DATA_W         = 24;
  localparam int CFG_INDEX_W        = 3;
  localparam int COUNT_BITS_DEFAULT = 24;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ATTACK_LEN    = 3'd0,
    REG_DECAY_LEN     = 3'd1,
    REG_RELEASE_LEN   = 3'd2,
    REG_SUSTAIN_LEVEL = 3'd3,
    REG_KEYBOARD_MODE = 3'd4,
    REG_GATE_REPEAT   = 3'd5
  } cfg_reg_t;

  // Envelope segment, also the phase code on the output.
  typedef enum logic [PHASE_W-1:0] {
    SEG_IDLE    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4
  } segment_t;

  // How the output level of one sample is formed.
  typedef enum logic [2:0] {
    OP_ZERO    = 3'd0,
    OP_SUSTAIN = 3'd1,
    OP_ATTACK  = 3'd2,
    OP_DECAY   = 3'd3,
    OP_RELEASE = 3'd4
  } level_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_DONE = 2'd2
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_MUL  = 2'd1,
    DV_DIV  = 2'd2,
    DV_FIN  = 2'd3
  } div_state_t;

  typedef struct packed {
    logic [LEN_W-1:0]   attack_len;
    logic [LEN_W-1:0]   decay_len;
    logic [LEN_W-1:0]   release_len;
    logic [LEVEL_W-1:0] sustain_level;
    logic               keyboard_mode;
    logic               gate_repeat;
  } cfg_t;

  typedef struct packed {
    segment_t  segment;
    level_op_t op;
    logic      need_div;
  } step_ctl_t;

endpackage

`default_nettype wire

@@ src/adsr_ifs.sv @@
// ----------------------------------------------------------------------------
// adsr_in_if / adsr_out_if
// Valid/ready channels for the sample ticks going in and the envelope
// samples coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_in_if import adsr_pkg::*; ();
  logic valid;
  logic ready;
  logic key_gate;
  logic key_trigger;
  logic lfo_trigger;

  modport source (output valid, output key_gate, output key_trigger,
                  output lfo_trigger, input ready);
  modport sink   (input valid, input key_gate, input key_trigger,
                  input lfo_trigger, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

`default_nettype wire

@@ src/adsr_step.sv @@
// ----------------------------------------------------------------------------
// adsr_step
// Segment decision logic for one sample: applies triggers, end-of-segment
// cascades and releases, and picks the operands of the level division.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_step import adsr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  cfg_t                  cfg,
  input  segment_t              segment,
  input  logic [COUNT_BITS-1:0] elapsed,
  input  logic [COUNT_BITS-1:0] remaining,
  input  logic                  key_gate,
  input  logic                  key_trigger,
  input  logic                  lfo_trigger,
  output step_ctl_t             ctl,
  output logic [COUNT_BITS-1:0] elapsed_next,
  output logic [COUNT_BITS-1:0] remaining_next,
  output logic [LEVEL_W-1:0]    sustain,
  output logic [LEVEL_W-1:0]    mul_a,
  output logic [COUNT_BITS-1:0] mul_b,
  output logic [COUNT_BITS:0]   den
);

  localparam int WIDE_W = (LEN_W > COUNT_BITS) ? LEN_W : COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Lengths that do not fit the counters saturate to the largest count.
  function automatic logic [COUNT_BITS-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [WIDE_W-1:0] wide;
    logic [WIDE_W-1:0] top_count;
    wide      = WIDE_W'(len);
    top_count = WIDE_W'(COUNT_MAX);
    clamp_len = (wide > top_count) ? COUNT_BITS'(top_count) : COUNT_BITS'(wide);
  endfunction

  segment_t              seg_c;
  level_op_t             op_c;
  logic [COUNT_BITS-1:0] elp_c;
  logic [COUNT_BITS-1:0] rem_c;
  logic                  trig;
  logic                  kbd;

  always_comb begin
    sustain = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;
    kbd     = cfg.keyboard_mode;
    trig    = kbd ? key_trigger
                  : (cfg.gate_repeat ? (key_gate & lfo_trigger) : lfo_trigger);

    seg_c = segment;
    elp_c = elapsed;
    rem_c = remaining;
    op_c  = OP_ZERO;

    if (trig) begin
      seg_c = SEG_ATTACK;
      elp_c = '0;
      rem_c = clamp_len(cfg.attack_len);
    end
    // Zero-length segments fall through within the same sample.
    if (seg_c == SEG_ATTACK) begin
      if (rem_c != '0) begin
        op_c = OP_ATTACK;
      end else begin
        seg_c = SEG_DECAY;
        elp_c = '0;
        rem_c = clamp_len(cfg.decay_len);
      end
    end
    if (seg_c == SEG_DECAY) begin
      if (rem_c != '0) begin
        op_c = OP_DECAY;
      end else begin
        seg_c = SEG_SUSTAIN;
      end
    end
    if (seg_c == SEG_SUSTAIN) begin
      op_c = OP_SUSTAIN;
    end
    if ((kbd && !key_gate && seg_c != SEG_IDLE && seg_c != SEG_RELEASE) ||
        (!kbd && seg_c == SEG_SUSTAIN)) begin
      seg_c = SEG_RELEASE;
      elp_c = '0;
      rem_c = clamp_len(cfg.release_len);
    end
    if (seg_c == SEG_RELEASE) begin
      if (rem_c != '0) begin
        op_c = OP_RELEASE;
      end else begin
        seg_c = SEG_IDLE;
      end
    end
    if (seg_c == SEG_IDLE) begin
      op_c = OP_ZERO;
    end

    // The divisor is the segment length, fixed while the segment runs.
    den = {1'b0, elp_c} + {1'b0, rem_c};
    case (op_c)
      OP_ATTACK: begin
        mul_a = FULL_SCALE;
        mul_b = elp_c;
      end
      OP_DECAY: begin
        mul_a = FULL_SCALE - sustain;
        mul_b = elp_c;
      end
      OP_RELEASE: begin
        mul_a = sustain;
        mul_b = rem_c;
      end
      default: begin
        mul_a = '0;
        mul_b = elp_c;
      end
    endcase

    if (seg_c != SEG_IDLE && seg_c != SEG_SUSTAIN) begin
      elapsed_next   = elp_c + COUNT_BITS'(1);
      remaining_next = (rem_c != '0) ? rem_c - COUNT_BITS'(1) : '0;
    end else begin
      elapsed_next   = elp_c;
      remaining_next = rem_c;
    end

    ctl.segment  = seg_c;
    ctl.op       = op_c;
    ctl.need_div = (op_c == OP_ATTACK) || (op_c == OP_DECAY) || (op_c == OP_RELEASE);
  end

endmodule

`default_nettype wire

@@ src/adsr_div.sv @@
// ----------------------------------------------------------------------------
// adsr_div
// Shared multiply-divide unit: forms a*b in its multiply state, then divides
// it by den with a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adsr_div import adsr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [LEVEL_W-1:0]    mul_a,
  input  logic [COUNT_BITS-1:0] mul_b,
  input  logic [COUNT_BITS:0]   den,
  output logic                  done,
  output logic [LEVEL_W-1:0]    quotient
);

  localparam int DEN_W  = COUNT_BITS + 1;
  localparam int PROD_W = LEVEL_W + COUNT_BITS;
  localparam int CNT_W  = $clog2(LEVEL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEVEL_W - 1);

  div_state_t            state;
  div_state_t            state_next;
  logic [LEVEL_W-1:0]    a_q;
  logic [COUNT_BITS-1:0] b_q;
  logic [DEN_W-1:0]      den_q;
  logic [DEN_W-1:0]      rem;
  logic [LEVEL_W-1:0]    quo;
  logic [CNT_W-1:0]      count;
  logic [PROD_W-1:0]     product;
  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  fits;

  assign product = PROD_W'(a_q) * PROD_W'(b_q);
  assign trial   = {rem, quo[LEVEL_W-1]};
  assign diff    = trial - {1'b0, den_q};
  assign fits    = (trial >= {1'b0, den_q});

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (start) state_next = DV_MUL;
      DV_MUL:  state_next = DV_DIV;
      DV_DIV:  if (count == LAST_STEP) state_next = DV_FIN;
      DV_FIN:  state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      DV_FIN:  done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          a_q   <= mul_a;
          b_q   <= mul_b;
          den_q <= den;
        end
      end
      DV_MUL: begin
        // The high part of the product is below the divisor, so the
        // quotient fits in LEVEL_W bits.
        rem   <= {1'b0, product[PROD_W-1:LEVEL_W]};
        quo   <= product[LEVEL_W-1:0];
        count <= '0;
      end
      DV_DIV: begin
        rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo   <= {quo[LEVEL_W-2:0], fits};
        count <= count + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  `ASSERT_CLK(a_div_start_idle, start |-> (state == DV_IDLE), "divider started while busy")
  `ASSERT_CLK(a_div_rem_bound, (state == DV_DIV) |-> (rem < den_q), "partial remainder not below divisor")

endmodule

`default_nettype wire

@@ src/adsr_envelope_generator.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear attack/decay/sustain/release envelope, one output sample per tick.
// A tick in attack, decay or release goes through the shared multiply-divide
// unit, which passes its multiply state and then its 17 one-bit divide steps
// before the level is registered. Idle and sustain ticks need no division.
// A new tick is taken only after the previous sample has entered the output
// register. A synchronous reset returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adsr_envelope_generator import adsr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  adsr_in_if.sink                tick,
  adsr_out_if.source             envelope
);

  // Configuration registers. They are to be only written while no tick is in
  // flight (the block does not enforce this), so the step logic reads them directly.
  cfg_t cfg;

  // Envelope state committed when a tick is accepted.
  segment_t              segment;
  logic [COUNT_BITS-1:0] elapsed;
  logic [COUNT_BITS-1:0] remaining;

  // Sequencer and result registers.
  ctrl_state_t        state;
  ctrl_state_t        state_next;
  level_op_t          op_q;
  logic [LEVEL_W-1:0] res_level;
  logic [PHASE_W-1:0] res_phase;

  // Output register. It parts the two sides: a new tick can be accepted
  // while the previous sample still waits to be taken.
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [PHASE_W-1:0] out_phase;

  step_ctl_t             ctl;
  logic [COUNT_BITS-1:0] elapsed_next;
  logic [COUNT_BITS-1:0] remaining_next;
  logic [LEVEL_W-1:0]    sustain;
  logic [LEVEL_W-1:0]    mul_a;
  logic [COUNT_BITS-1:0] mul_b;
  logic [COUNT_BITS:0]   den;
  logic                  div_start;
  logic                  div_done;
  logic [LEVEL_W-1:0]    quotient;

  logic tick_ready;
  logic tick_accept;
  logic out_free;
  logic load_out;

  // --------------------------------------------------------------------------
  // Configuration write port. Unknown indexes are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_len    <= '0;
      cfg.decay_len     <= '0;
      cfg.release_len   <= '0;
      cfg.sustain_level <= FULL_SCALE;
      cfg.keyboard_mode <= 1'b1;
      cfg.gate_repeat   <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ATTACK_LEN:    cfg.attack_len    <= wr_data[LEN_W-1:0];
        REG_DECAY_LEN:     cfg.decay_len     <= wr_data[LEN_W-1:0];
        REG_RELEASE_LEN:   cfg.release_len   <= wr_data[LEN_W-1:0];
        REG_SUSTAIN_LEVEL: cfg.sustain_level <= wr_data[LEVEL_W-1:0];
        REG_KEYBOARD_MODE: cfg.keyboard_mode <= wr_data[0];
        REG_GATE_REPEAT:   cfg.gate_repeat   <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Segment decisions for the tick on the input channel. All the cascading
  // of zero-length segments happens here in one pass; only the level ramp
  // needs the divider.
  // --------------------------------------------------------------------------
  adsr_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .cfg           (cfg),
    .segment       (segment),
    .elapsed       (elapsed),
    .remaining     (remaining),
    .key_gate      (tick.key_gate),
    .key_trigger   (tick.key_trigger),
    .lfo_trigger   (tick.lfo_trigger),
    .ctl           (ctl),
    .elapsed_next  (elapsed_next),
    .remaining_next(remaining_next),
    .sustain       (sustain),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .den           (den)
  );

  // The ramp quotient is floor(a * b / (elapsed + remaining)); operands are
  // captured by the unit on the accepting edge.
  adsr_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .den     (den),
    .done    (div_done),
    .quotient(quotient)
  );

  // --------------------------------------------------------------------------
  // Sequencer: wait for a tick, run the divider when the level needs it,
  // then hand the sample to the output register once it is free.
  // --------------------------------------------------------------------------
  assign tick_accept = tick.valid && tick_ready;
  assign out_free    = !out_valid || envelope.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_accept) begin
          state_next = ctl.need_div ? ST_CALC : ST_DONE;
        end
      end
      ST_CALC: if (div_done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tick_ready = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: tick_ready = 1'b1;
      ST_DONE: load_out   = out_free;
      default: begin
      end
    endcase
  end

  assign div_start = tick_accept && ctl.need_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      segment   <= SEG_IDLE;
      elapsed   <= '0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (tick_accept) begin
        segment   <= ctl.segment;
        elapsed   <= elapsed_next;
        remaining <= remaining_next;
      end
    end
  end

  // Sustain and idle levels are known at once; ramps take the quotient.
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      op_q      <= ctl.op;
      res_phase <= ctl.segment;
      res_level <= (ctl.op == OP_SUSTAIN) ? sustain : '0;
    end else if (state == ST_CALC && div_done) begin
      res_level <= (op_q == OP_DECAY) ? FULL_SCALE - quotient : quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (envelope.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level <= res_level;
      out_phase <= res_phase;
    end
  end

  assign tick.ready     = tick_ready;
  assign envelope.valid = out_valid;
  assign envelope.level = out_level;
  assign envelope.phase = out_phase;

  // --------------------------------------------------------------------------
  // Checks on the sequencer and on the sample values.
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_done_in_calc, div_done |-> (state == ST_CALC), "divider finished outside of a calculation")
  `ASSERT_CLK(a_calc_launch, (tick_accept && ctl.need_div) |=> (state == ST_CALC), "ramp tick did not start the divider")
  `ASSERT_CLK(a_idle_silent, (out_valid && (out_phase == SEG_IDLE)) |-> (out_level == '0), "idle sample with nonzero level")
  `ASSERT_CLK(a_level_range, out_valid |-> (out_level <= FULL_SCALE), "level above full scale")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

endmodule

`default_nettype wire
